// ===== design/prd_pkg.sv =====
package prd_pkg;

    // defaults for the top-level parameters
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int COORD_WIDTH_DEF   = 32;

    // angle field: signed Q9.7 degrees
    localparam int ANGLE_W      = 17;
    localparam int TURN_W       = 18;      // signed, holds the negated angle
    localparam int TURN_U_W     = 16;      // reduced turn, 0 .. FULL_TURN-1
    localparam int FULL_TURN    = 46080;   // 360 degrees in Q9.7
    localparam int QUARTER_TURN = 11520;   // 90 degrees in Q9.7
    localparam int RES_W        = 14;      // residual inside one quadrant

    // residual to binary angle: z = floor((r * 2^22 + 22) / 45)
    // r = 45 * digit + rem, digit by reciprocal multiply, rem through a table
    localparam int REM_DIV     = 45;
    localparam int RECIP_W     = 21;
    localparam int RECIP45     = 1491309;  // ceil(2^26 / 45)
    localparam int RECIP_SHIFT = 26;
    localparam int DIGIT_W     = 8;
    localparam int REM_W       = 6;
    localparam int FRAC_W      = 22;

    // datapath
    localparam int GUARD_BITS = 8;
    localparam int HEADROOM   = 3;         // negation plus CORDIC growth
    localparam int Z_W        = 33;

    localparam int          ATAN_ENTRIES = 30;
    localparam logic [31:0] INV_GAIN     = 32'd2608131497;

    typedef logic [31:0] atan_tab_t [0:ATAN_ENTRIES-1];

    // round(atan(2^-i) * 2^32 / 360 deg)
    localparam atan_tab_t ATAN_TAB = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef logic [FRAC_W-1:0] frac_tab_t [0:REM_DIV-1];

    function automatic frac_tab_t build_frac_tab();
        frac_tab_t tab;
        for (int b = 0; b < REM_DIV; b++)
        begin
            tab[b] = FRAC_W'((64'(b) * 64'd4194304 + 64'd22) / 64'd45);
        end
        return tab;
    endfunction

    localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

// ===== design/prd_reduce.sv =====
// Angle reduction, quadrant fold and residual-to-binary-angle conversion.
// Four register stages.
module prd_reduce #(
    parameter int COORD_WIDTH = prd_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [COORD_WIDTH-1:0]         x_in,
    input  logic signed [COORD_WIDTH-1:0]         y_in,
    input  logic signed [prd_pkg::ANGLE_W-1:0]    angle_deg,
    output logic                                  out_valid,
    output logic signed [COORD_WIDTH+prd_pkg::GUARD_BITS+prd_pkg::HEADROOM-1:0] x_out,
    output logic signed [COORD_WIDTH+prd_pkg::GUARD_BITS+prd_pkg::HEADROOM-1:0] y_out,
    output logic signed [prd_pkg::Z_W-1:0]        z_out
);

    localparam int IW = COORD_WIDTH + prd_pkg::GUARD_BITS + prd_pkg::HEADROOM;
    localparam int XW = COORD_WIDTH + 1;

    localparam logic signed [prd_pkg::TURN_W-1:0] FULL_S =
        prd_pkg::TURN_W'(prd_pkg::FULL_TURN);
    localparam logic signed [prd_pkg::TURN_W-1:0] TWO_FULL_S =
        prd_pkg::TURN_W'(2 * prd_pkg::FULL_TURN);
    localparam logic [prd_pkg::TURN_U_W-1:0] T1 =
        prd_pkg::TURN_U_W'(prd_pkg::QUARTER_TURN);
    localparam logic [prd_pkg::TURN_U_W-1:0] T2 =
        prd_pkg::TURN_U_W'(2 * prd_pkg::QUARTER_TURN);
    localparam logic [prd_pkg::TURN_U_W-1:0] T3 =
        prd_pkg::TURN_U_W'(3 * prd_pkg::QUARTER_TURN);
    localparam logic [prd_pkg::RECIP_W-1:0] RECIP =
        prd_pkg::RECIP_W'(prd_pkg::RECIP45);

    typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_t;

    logic [3:0] valid_reg;

    // stage 1: counter-clockwise turn reduced to [0, 360)
    logic signed [prd_pkg::TURN_W-1:0]   neg_ang;
    logic signed [prd_pkg::TURN_W-1:0]   turn_full;
    logic [prd_pkg::TURN_U_W-1:0]        turn_reg;
    logic signed [COORD_WIDTH-1:0]       x1_reg;
    logic signed [COORD_WIDTH-1:0]       y1_reg;

    assign neg_ang = -$signed({angle_deg[prd_pkg::ANGLE_W-1], angle_deg});

    always_comb
    begin
        if (neg_ang < -FULL_S)
        begin
            turn_full = neg_ang + TWO_FULL_S;
        end
        else if (neg_ang < 0)
        begin
            turn_full = neg_ang + FULL_S;
        end
        else if (neg_ang >= FULL_S)
        begin
            turn_full = neg_ang - FULL_S;
        end
        else
        begin
            turn_full = neg_ang;
        end
    end

    // stage 2: quadrant fold, exact
    quad_t                        quad;
    logic [prd_pkg::TURN_U_W-1:0] resid_wide;
    logic signed [XW-1:0]         xe;
    logic signed [XW-1:0]         ye;
    logic signed [XW-1:0]         xq;
    logic signed [XW-1:0]         yq;
    logic [prd_pkg::RES_W-1:0]    r2_reg;
    logic signed [XW-1:0]         x2_reg;
    logic signed [XW-1:0]         y2_reg;

    assign xe = XW'(x1_reg);
    assign ye = XW'(y1_reg);

    always_comb
    begin
        if (turn_reg >= T3)
        begin
            quad       = QUAD_270;
            resid_wide = turn_reg - T3;
        end
        else if (turn_reg >= T2)
        begin
            quad       = QUAD_180;
            resid_wide = turn_reg - T2;
        end
        else if (turn_reg >= T1)
        begin
            quad       = QUAD_90;
            resid_wide = turn_reg - T1;
        end
        else
        begin
            quad       = QUAD_0;
            resid_wide = turn_reg;
        end
    end

    always_comb
    begin
        case (quad)
            QUAD_90:
            begin
                xq = -ye;
                yq = xe;
            end
            QUAD_180:
            begin
                xq = -xe;
                yq = -ye;
            end
            QUAD_270:
            begin
                xq = ye;
                yq = -xe;
            end
            default:
            begin
                xq = xe;
                yq = ye;
            end
        endcase
    end

    // stage 3: digit = floor(r / 45) by reciprocal multiply
    logic [prd_pkg::RES_W+prd_pkg::RECIP_W-1:0] recip_prod;
    logic [prd_pkg::DIGIT_W-1:0]                digit3_reg;
    logic [prd_pkg::RES_W-1:0]                  r3_reg;
    logic signed [XW-1:0]                       x3_reg;
    logic signed [XW-1:0]                       y3_reg;

    assign recip_prod = (prd_pkg::RES_W+prd_pkg::RECIP_W)'(r2_reg) *
                        (prd_pkg::RES_W+prd_pkg::RECIP_W)'(RECIP);

    // stage 4: z = digit * 2^22 + table(r mod 45)
    logic [prd_pkg::RES_W-1:0] back_mul;
    logic [prd_pkg::RES_W-1:0] rem_wide;
    logic [prd_pkg::REM_W-1:0] rem_idx;
    logic signed [prd_pkg::Z_W-1:0] z_next;
    logic signed [IW-1:0]           x4_reg;
    logic signed [IW-1:0]           y4_reg;
    logic signed [prd_pkg::Z_W-1:0] z_reg;

    assign back_mul = prd_pkg::RES_W'(digit3_reg) * prd_pkg::RES_W'(prd_pkg::REM_DIV);
    assign rem_wide = r3_reg - back_mul;
    assign rem_idx  = rem_wide[prd_pkg::REM_W-1:0];
    assign z_next   = $signed(prd_pkg::Z_W'({digit3_reg, {prd_pkg::FRAC_W{1'b0}}})
                      + prd_pkg::Z_W'(prd_pkg::FRAC_TAB[rem_idx]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            turn_reg   <= turn_full[prd_pkg::TURN_U_W-1:0];
            x1_reg     <= x_in;
            y1_reg     <= y_in;
            r2_reg     <= resid_wide[prd_pkg::RES_W-1:0];
            x2_reg     <= xq;
            y2_reg     <= yq;
            digit3_reg <= recip_prod[prd_pkg::RECIP_SHIFT +: prd_pkg::DIGIT_W];
            r3_reg     <= r2_reg;
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;
            x4_reg     <= IW'(x3_reg) <<< prd_pkg::GUARD_BITS;
            y4_reg     <= IW'(y3_reg) <<< prd_pkg::GUARD_BITS;
            z_reg      <= z_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[3];
    assign x_out     = x4_reg;
    assign y_out     = y4_reg;
    assign z_out     = z_reg;

endmodule

// ===== design/prd_cordic.sv =====
// Rotation-mode CORDIC, one register stage per iteration.
module prd_cordic #(
    parameter int COORD_WIDTH   = prd_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = prd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [COORD_WIDTH+prd_pkg::GUARD_BITS+prd_pkg::HEADROOM-1:0] x_in,
    input  logic signed [COORD_WIDTH+prd_pkg::GUARD_BITS+prd_pkg::HEADROOM-1:0] y_in,
    input  logic signed [prd_pkg::Z_W-1:0] z_in,
    output logic                           out_valid,
    output logic signed [COORD_WIDTH+prd_pkg::GUARD_BITS+prd_pkg::HEADROOM-1:0] x_out,
    output logic signed [COORD_WIDTH+prd_pkg::GUARD_BITS+prd_pkg::HEADROOM-1:0] y_out
);

    localparam int IW = COORD_WIDTH + prd_pkg::GUARD_BITS + prd_pkg::HEADROOM;

    logic signed [IW-1:0]           x_reg [0:CORDIC_STAGES-1];
    logic signed [IW-1:0]           y_reg [0:CORDIC_STAGES-1];
    logic signed [prd_pkg::Z_W-1:0] z_reg [0:CORDIC_STAGES-1];
    logic [CORDIC_STAGES-1:0]       valid_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [IW-1:0]           x_prev;
        logic signed [IW-1:0]           y_prev;
        logic signed [prd_pkg::Z_W-1:0] z_prev;
        logic signed [IW-1:0]           xs;
        logic signed [IW-1:0]           ys;
        logic signed [prd_pkg::Z_W-1:0] atan_c;

        if (i == 0)
        begin : g_first
            assign x_prev = x_in;
            assign y_prev = y_in;
            assign z_prev = z_in;
        end
        else
        begin : g_next
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign z_prev = z_reg[i-1];
        end

        assign xs     = x_prev >>> i;
        assign ys     = y_prev >>> i;
        assign atan_c = $signed({1'b0, prd_pkg::ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_prev[prd_pkg::Z_W-1])
                begin
                    x_reg[i] <= x_prev - ys;
                    y_reg[i] <= y_prev + xs;
                    z_reg[i] <= z_prev - atan_c;
                end
                else
                begin
                    x_reg[i] <= x_prev + ys;
                    y_reg[i] <= y_prev - xs;
                    z_reg[i] <= z_prev + atan_c;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[CORDIC_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[CORDIC_STAGES-1];
    assign x_out     = x_reg[CORDIC_STAGES-1];
    assign y_out     = y_reg[CORDIC_STAGES-1];

endmodule

// ===== design/prd_gain.sv =====
// Gain correction, round half away from zero, saturation.
// Two register stages; the final round/clip feeds the output buffer.
module prd_gain #(
    parameter int COORD_WIDTH = prd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH+prd_pkg::GUARD_BITS+prd_pkg::HEADROOM-1:0] x_in,
    input  logic signed [COORD_WIDTH+prd_pkg::GUARD_BITS+prd_pkg::HEADROOM-1:0] y_in,
    output logic                          res_valid,
    output logic signed [COORD_WIDTH-1:0] x_res,
    output logic signed [COORD_WIDTH-1:0] y_res,
    output logic                          saturated
);

    localparam int IW    = COORD_WIDTH + prd_pkg::GUARD_BITS + prd_pkg::HEADROOM;
    localparam int HI_W  = (IW > 32) ? IW - 32 : 1;
    localparam int PAD_W = 32 + HI_W;
    localparam int P_W   = HI_W + 33;
    localparam int R_W   = P_W - prd_pkg::GUARD_BITS;

    localparam logic [P_W-1:0] HALF_LSB = P_W'(64'd1 << (prd_pkg::GUARD_BITS - 1));
    localparam logic [R_W-1:0] POS_MAX  = R_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
    localparam logic [R_W-1:0] NEG_MAG  = R_W'(64'd1 << (COORD_WIDTH - 1));
    localparam logic [COORD_WIDTH-1:0] OUT_MAX = COORD_WIDTH'(POS_MAX);
    localparam logic [COORD_WIDTH-1:0] OUT_MIN = COORD_WIDTH'(NEG_MAG);

    logic signed [IW-1:0]   lane_in [0:1];
    logic [COORD_WIDTH-1:0] lane_out [0:1];
    logic [1:0]             lane_sat;
    logic [1:0]             valid_reg;

    assign lane_in[0] = x_in;
    assign lane_in[1] = y_in;

    for (genvar k = 0; k < 2; k++)
    begin : g_lane
        logic              neg1_reg;
        logic [IW-1:0]     mag1_reg;
        logic [PAD_W-1:0]  mag_pad;
        logic              neg2_reg;
        logic [63:0]       pl2_reg;
        logic [P_W-2:0]    ph2_reg;
        logic [P_W-1:0]    prod_sum;
        logic [P_W-1:0]    rounded;
        logic [R_W-1:0]    mag_r;
        logic              sat_pos;
        logic              sat_neg;

        assign mag_pad = PAD_W'(mag1_reg);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg1_reg <= lane_in[k][IW-1];
                mag1_reg <= lane_in[k][IW-1] ? $unsigned(-lane_in[k])
                                             : $unsigned(lane_in[k]);
                neg2_reg <= neg1_reg;
                pl2_reg  <= 64'(mag_pad[31:0]) * 64'(prd_pkg::INV_GAIN);
                ph2_reg  <= (P_W-1)'(mag_pad[PAD_W-1:32]) * (P_W-1)'(prd_pkg::INV_GAIN);
            end
        end

        // floor(m * INV_GAIN / 2^32), then drop the guard bits with rounding
        assign prod_sum = P_W'(ph2_reg) + P_W'(pl2_reg[63:32]);
        assign rounded  = prod_sum + HALF_LSB;
        assign mag_r    = rounded[P_W-1:prd_pkg::GUARD_BITS];
        assign sat_pos  = !neg2_reg && (mag_r > POS_MAX);
        assign sat_neg  = neg2_reg && (mag_r > NEG_MAG);

        always_comb
        begin
            if (sat_pos)
            begin
                lane_out[k] = OUT_MAX;
            end
            else if (sat_neg)
            begin
                lane_out[k] = OUT_MIN;
            end
            else if (neg2_reg)
            begin
                lane_out[k] = -mag_r[COORD_WIDTH-1:0];
            end
            else
            begin
                lane_out[k] = mag_r[COORD_WIDTH-1:0];
            end
        end

        assign lane_sat[k] = sat_pos | sat_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    assign res_valid = valid_reg[1];
    assign x_res     = $signed(lane_out[0]);
    assign y_res     = $signed(lane_out[1]);
    assign saturated = |lane_sat;

endmodule

// ===== design/prd_out_buf.sv =====
// Two-word output buffer: head drives the master side, spare catches the
// word that arrives while the head is stalled. Ready depends on the spare
// flag only, so no path runs from m_tready back to s_tready.
module prd_out_buf #(
    parameter int DATA_W = 72
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              can_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              head_vld_reg;
    logic              head_vld_next;
    logic              spare_vld_reg;
    logic              spare_vld_next;
    logic [DATA_W-1:0] head_reg;
    logic [DATA_W-1:0] spare_reg;
    logic              pop;
    logic              load_in;
    logic              load_spare;
    logic              keep_in;

    assign pop = head_vld_reg && out_ready;

    always_comb
    begin
        head_vld_next  = head_vld_reg;
        spare_vld_next = spare_vld_reg;
        load_in        = 1'b0;
        load_spare     = 1'b0;
        keep_in        = 1'b0;
        if (spare_vld_reg)
        begin
            if (pop)
            begin
                load_spare     = 1'b1;
                spare_vld_next = 1'b0;
            end
        end
        else if (head_vld_reg)
        begin
            if (push && pop)
            begin
                load_in = 1'b1;
            end
            else if (push)
            begin
                keep_in        = 1'b1;
                spare_vld_next = 1'b1;
            end
            else if (pop)
            begin
                head_vld_next = 1'b0;
            end
        end
        else if (push)
        begin
            load_in       = 1'b1;
            head_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            head_reg <= push_data;
        end
        else if (load_spare)
        begin
            head_reg <= spare_reg;
        end
        if (keep_in)
        begin
            spare_reg <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg  <= 1'b0;
            spare_vld_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg  <= head_vld_next;
            spare_vld_reg <= spare_vld_next;
        end
    end

    assign can_take  = !spare_vld_reg;
    assign out_valid = head_vld_reg;
    assign out_data  = head_reg;

endmodule

// ===== design/point_rotate_degrees_core.sv =====
// Throughput: one word per cycle unless stalled; every stage is registered and the CORDIC has one
//   register stage per iteration, so a new point can enter on every clock while the buffer has room.
// Stalls: the whole pipeline holds while the two-word output buffer is full.
// Reset: rst_n asynchronous, active low; clears valid bits and the output buffer,
//   datapath registers are not reset. No state survives between points.
module point_rotate_degrees_core #(
    parameter int CORDIC_STAGES = prd_pkg::CORDIC_STAGES_DEF,
    parameter int COORD_WIDTH   = prd_pkg::COORD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,

    // slave side: one point and angle per word
    input  logic s_tvalid,
    output logic s_tready,
    // s_tdata fields, low bit up: x_in, y_in, angle_deg (Q9.7), zero pad
    input  logic [((2*COORD_WIDTH+prd_pkg::ANGLE_W+7)/8)*8-1:0] s_tdata,

    // master side: one rotated point per word
    output logic m_tvalid,
    input  logic m_tready,
    // m_tdata fields, low bit up: x_out, y_out, saturated, zero pad
    output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] m_tdata
);

    // guarded internal coordinate width: sign room for negating the most
    // negative input, CORDIC gain headroom, and fraction guard bits
    localparam int IW  = COORD_WIDTH + prd_pkg::GUARD_BITS + prd_pkg::HEADROOM;
    localparam int M_W = ((2*COORD_WIDTH+1+7)/8)*8;
    localparam int ANG_LO = 2*COORD_WIDTH;

    // one global advance: every stage moves when the output buffer has room
    logic en;

    logic signed [COORD_WIDTH-1:0]          x_in;
    logic signed [COORD_WIDTH-1:0]          y_in;
    logic signed [prd_pkg::ANGLE_W-1:0]     angle_deg;

    logic                                   red_valid;
    logic signed [IW-1:0]                   red_x;
    logic signed [IW-1:0]                   red_y;
    logic signed [prd_pkg::Z_W-1:0]         red_z;

    logic                                   rot_valid;
    logic signed [IW-1:0]                   rot_x;
    logic signed [IW-1:0]                   rot_y;

    logic                                   res_valid;
    logic signed [COORD_WIDTH-1:0]          x_res;
    logic signed [COORD_WIDTH-1:0]          y_res;
    logic                                   sat_res;

    logic                                   push;
    logic [M_W-1:0]                         push_word;

    assign x_in      = $signed(s_tdata[COORD_WIDTH-1:0]);
    assign y_in      = $signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
    assign angle_deg = $signed(s_tdata[ANG_LO +: prd_pkg::ANGLE_W]);

    assign s_tready = en;

    // angle fold to [0, 360), quadrant swap, residual to binary angle (2^30 = 90 deg)
    prd_reduce #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .x_in      (x_in),
        .y_in      (y_in),
        .angle_deg (angle_deg),
        .out_valid (red_valid),
        .x_out     (red_x),
        .y_out     (red_y),
        .z_out     (red_z)
    );

    // residual rotation below 90 degrees
    prd_cordic #(
        .COORD_WIDTH   (COORD_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (red_valid),
        .x_in      (red_x),
        .y_in      (red_y),
        .z_in      (red_z),
        .out_valid (rot_valid),
        .x_out     (rot_x),
        .y_out     (rot_y)
    );

    // multiply by 1/K, strip guard bits, clip to the coordinate range
    prd_gain #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .x_in      (rot_x),
        .y_in      (rot_y),
        .res_valid (res_valid),
        .x_res     (x_res),
        .y_res     (y_res),
        .saturated (sat_res)
    );

    assign push      = en && res_valid;
    assign push_word = M_W'({sat_res, y_res, x_res});

    // output register plus skid word
    prd_out_buf #(
        .DATA_W (M_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_word),
        .can_take  (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // backpressure only comes from a full buffer, which always shows a word
    a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no word on the master side");

    // a full buffer drains only through the master side
    a_full_until_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !m_tready |=> !s_tready)
        else $error("buffer lost a word while stalled");

    // the saturation flag comes with at least one coordinate at a range limit
    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2*COORD_WIDTH] |->
            (m_tdata[COORD_WIDTH-1:0] == C_MAX) ||
            (m_tdata[COORD_WIDTH-1:0] == C_MIN) ||
            (m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] == C_MAX) ||
            (m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] == C_MIN))
        else $error("saturated set without a clipped coordinate");
`endif

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    localparam int STAGES  = prd_pkg::CORDIC_STAGES_DEF;
    localparam int CW      = prd_pkg::COORD_WIDTH_DEF;
    localparam int ANGLE_W = prd_pkg::ANGLE_W;
    localparam int S_W     = ((2*CW+ANGLE_W+7)/8)*8;
    localparam int M_W     = ((2*CW+1+7)/8)*8;

    // angle units: Q9.7 degrees
    localparam int DEG     = 128;
    localparam int DEG90   = 90*DEG;
    localparam int DEG360  = 360*DEG;

    // Q16.16 coordinates
    localparam logic [CW-1:0] C_ONE = CW'(32'h0001_0000);
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] C_NEG1 = {CW{1'b1}};

    localparam int           PAD_FRAC = 8;    // extra fraction bits in the rotator
    localparam logic [63:0]  RECIP_K  = 64'd2608131497;
    localparam int           LATENCY  = STAGES + 7;

    // binary angle per stage, 2^32 = one full turn
    localparam longint ARCTAN_BA [0:29] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
        'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
        'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
        'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
        'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          sat;
    } rot_word_t;

    logic           clk      = 1'b0;
    logic           rst_n    = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    rot_word_t rotated_q [$];
    int        mismatch_count = 0;
    int        result_idx     = 0;
    bit        gaps_on        = 1'b1;
    int        stall_left     = 0;

    point_rotate_degrees_core #(
        .CORDIC_STAGES (STAGES),
        .COORD_WIDTH   (CW)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // expected rotation, bit exact
    // ---------------------------------------------------------------
    function automatic longint apply_inv_gain(longint v);
        bit          neg;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] prod;
        logic [63:0] rnd;
        neg  = (v < 0);
        mag  = neg ? 64'(-v) : 64'(v);
        hi   = mag >> 32;
        lo   = mag & 64'hFFFF_FFFF;
        prod = hi * RECIP_K + ((lo * RECIP_K) >> 32);
        rnd  = (prod + (64'd1 << (PAD_FRAC-1))) >> PAD_FRAC;
        return neg ? -longint'(rnd) : longint'(rnd);
    endfunction

    function automatic longint clamp_coord(longint v, inout logic sat);
        longint hi_lim;
        longint lo_lim;
        hi_lim = (longint'(1) << (CW-1)) - 1;
        lo_lim = -hi_lim - 1;
        if (v > hi_lim)
        begin
            sat = 1'b1;
            return hi_lim;
        end
        if (v < lo_lim)
        begin
            sat = 1'b1;
            return lo_lim;
        end
        return v;
    endfunction

    function automatic rot_word_t rotate_point(logic [CW-1:0] xin, logic [CW-1:0] yin,
                                               logic [ANGLE_W-1:0] ang);
        longint    x;
        longint    y;
        longint    z;
        longint    xs;
        longint    ys;
        longint    tmp;
        int        a;
        int        t;
        int        quad;
        int        res;
        logic      sat;
        rot_word_t o;
        x   = $signed(xin);
        y   = $signed(yin);
        a   = $signed(ang);
        sat = 1'b0;

        // clockwise in, counter-clockwise turn out, folded into 0..360
        t = (-a) % DEG360;
        if (t < 0)
            t += DEG360;
        quad = t / DEG90;
        res  = t % DEG90;

        // whole quarter turns are exact
        case (quad)
            1:
            begin
                tmp = x; x = -y; y = tmp;
            end
            2:
            begin
                x = -x; y = -y;
            end
            3:
            begin
                tmp = x; x = y; y = -tmp;
            end
            default: ;
        endcase

        x = x * (longint'(1) << PAD_FRAC);
        y = y * (longint'(1) << PAD_FRAC);
        z = (longint'(res) * 64'sd4194304 + 64'sd22) / 64'sd45;

        for (int i = 0; i < STAGES && i < 30; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_BA[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_BA[i];
            end
        end

        x = clamp_coord(apply_inv_gain(x), sat);
        y = clamp_coord(apply_inv_gain(y), sat);
        o.x   = x[CW-1:0];
        o.y   = y[CW-1:0];
        o.sat = sat;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // slave side driver
    // ---------------------------------------------------------------
    task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [ANGLE_W-1:0] ang);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            s_tdata  <= S_W'({$urandom, $urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({ang, y, x});
        rotated_q.push_back(rotate_point(x, y, ang));
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [CW-1:0] pick_coord();
        logic [CW-1:0] v;
        v = CW'({$urandom, $urandom});
        case ($urandom_range(0, 7))
            0: v = C_MIN;
            1: v = C_MAX;
            2: v = $urandom_range(0, 1) ? C_NEG1 : CW'(1);
            3, 4: v = {{(CW-21){v[20]}}, v[20:0]};          // within +-16.0
            5: v = {{(CW-28){v[27]}}, v[27:0]};             // within +-2048.0
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        int a;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: a = int'($urandom_range(0, 2*DEG360)) - DEG360;
            6, 7: a = int'($urandom);                       // any pattern, past +-360 too
            default: a = (int'($urandom_range(0, 8)) - 4) * DEG90
                         + int'($urandom_range(0, 4)) - 2;  // quadrant seams
        endcase
        return ANGLE_W'(a);
    endfunction

    // ---------------------------------------------------------------
    // master side: stalls and result check
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("MISMATCH result %0d %s: got %h want %h (t=%0t)",
                 result_idx, what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        rot_word_t want;
        rot_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x   = m_tdata[CW-1:0];
            got.y   = m_tdata[2*CW-1:CW];
            got.sat = m_tdata[2*CW];
            if (rotated_q.size() == 0)
                report_mismatch("unexpected word", got.x, '0);
            else
            begin
                want = rotated_q.pop_front();
                if (got.x !== want.x)
                    report_mismatch("x_out", got.x, want.x);
                if (got.y !== want.y)
                    report_mismatch("y_out", got.y, want.y);
                if (got.sat !== want.sat)
                    report_mismatch("saturated", CW'(got.sat), CW'(want.sat));
            end
            result_idx++;
        end

        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed_points();
        send_point('0, '0, '0);
        send_point(C_ONE, '0, ANGLE_W'(DEG90));
        send_point(C_ONE, C_ONE, ANGLE_W'(-DEG90));
        send_point(C_ONE, '0, ANGLE_W'(180*DEG));
        send_point('0, C_ONE, ANGLE_W'(270*DEG));
        send_point(C_ONE, C_NEG1, ANGLE_W'(-270*DEG));
        send_point(C_MAX, C_MAX, ANGLE_W'(45*DEG));           // clips high
        send_point(C_MIN, C_MIN, ANGLE_W'(-45*DEG));          // clips low
        send_point(C_MIN, '0, '0);                            // most negative, untouched
        send_point(C_MIN, C_MAX, ANGLE_W'(180*DEG));          // negating the minimum
        send_point(C_MAX, C_MIN, ANGLE_W'(DEG360));
        send_point(C_MIN, C_MIN, ANGLE_W'(-DEG360));
        send_point(C_MAX, C_ONE, ANGLE_W'(500*DEG));          // past a full turn
        send_point(C_ONE, C_MAX, {1'b0, {(ANGLE_W-1){1'b1}}}); // largest pattern
        send_point(C_MIN, C_ONE, {1'b1, {(ANGLE_W-1){1'b0}}}); // smallest pattern
        send_point(C_ONE, C_ONE, ANGLE_W'(1));                // tiniest residual
        send_point(C_ONE, C_MIN, ANGLE_W'(DEG90-1));          // just under a quadrant
        send_point(CW'(1), C_NEG1, ANGLE_W'(30*DEG));
        send_point(C_NEG1, C_NEG1, ANGLE_W'(-60*DEG));
        send_point(C_MAX, '0, ANGLE_W'(DEG90));
    endtask

    task automatic test_random_points(int count);
        for (int n = 0; n < count; n++)
            send_point(pick_coord(), pick_coord(), pick_angle());
    endtask

    // sender holds off until the pipeline has fully drained, then resumes
    task automatic test_pause_until_drained();
        test_random_points(40);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (rotated_q.size() != 0);
        test_random_points(40);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        test_random_points(250);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_points();
        test_random_points(500);
        test_pause_until_drained();
        test_back_to_back();

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (rotated_q.size() != 0);
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog timeout, set many times over the worst case run time
    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== point_rotate_degrees_core.f =====
design/prd_pkg.sv
design/prd_reduce.sv
design/prd_cordic.sv
design/prd_gain.sv
design/prd_out_buf.sv
design/point_rotate_degrees_core.sv
verif/tb_top.sv
